/* rtl/core/crcg_pkg.sv */
// ----------------------------------------------------------------------------
// crcg_pkg
// Shared constants for the circle/ring contact gap and normal block.
// ----------------------------------------------------------------------------
package crcg_pkg;

	localparam int DEF_COORD_WIDTH = 32;

	// Normal components are signed Q1.16
	localparam int NORM_FRAC = 16;
	localparam int NORM_W    = NORM_FRAC + 2;
	// Unrounded quotient bits: |delta|/d stays below 1.5
	localparam int QUOT_W    = NORM_FRAC + 1;

	localparam int RADIUS_W   = 31;
	localparam int GAP_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SECOND = 2'd1;

endpackage

/* rtl/core/crcg_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// crcg_sqrt_cell
// One digit step of a restoring square root; passes side data along.
// ----------------------------------------------------------------------------
module crcg_sqrt_cell #(
	parameter int ROOT_W = 33,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_in,
	input  logic [2*ROOT_W-1:0] rad_in,
	input  logic [ROOT_W+1:0]   rem_in,
	input  logic [ROOT_W-1:0]   root_in,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                valid_out,
	output logic [2*ROOT_W-1:0] rad_out,
	output logic [ROOT_W+1:0]   rem_out,
	output logic [ROOT_W-1:0]   root_out,
	output logic [SIDE_W-1:0]   side_out
);

	localparam int REM_W = ROOT_W + 2;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	assign rem_sh = {rem_in[REM_W-3:0], rad_in[2*ROOT_W-1 -: 2]};
	assign trial  = {root_in, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_out  <= {rad_in[2*ROOT_W-3:0], 2'b00};
		rem_out  <= ge ? (rem_sh - trial) : rem_sh;
		root_out <= {root_in[ROOT_W-2:0], ge};
		side_out <= side_in;
	end

endmodule

/* rtl/core/crcg_div_cell.sv */
// ----------------------------------------------------------------------------
// crcg_div_cell
// One quotient bit of a restoring divider; passes side data along.
// ----------------------------------------------------------------------------
module crcg_div_cell #(
	parameter int DIV_W  = 33,
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_in,
	input  logic [DIV_W-1:0]            den_in,
	input  logic [DIV_W-1:0]            rem_in,
	input  logic [crcg_pkg::QUOT_W-1:0] nq_in,
	input  logic [SIDE_W-1:0]           side_in,
	output logic                        valid_out,
	output logic [DIV_W-1:0]            den_out,
	output logic [DIV_W-1:0]            rem_out,
	output logic [crcg_pkg::QUOT_W-1:0] nq_out,
	output logic [SIDE_W-1:0]           side_out
);

	import crcg_pkg::*;

	logic [DIV_W:0] rem2;
	logic [DIV_W:0] rsub;
	logic           ge;

	assign rem2 = {rem_in, nq_in[QUOT_W-1]};
	assign ge   = (rem2 >= {1'b0, den_in});
	assign rsub = rem2 - {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		den_out  <= den_in;
		rem_out  <= ge ? rsub[DIV_W-1:0] : rem2[DIV_W-1:0];
		nq_out   <= {nq_in[QUOT_W-2:0], ge};
		side_out <= side_in;
	end

endmodule

/* rtl/core/circle_ring_contact_gap_normal.sv */
// ----------------------------------------------------------------------------
// circle_ring_contact_gap_normal
// Contact gap and unit normal for a circle held inside a ring.
// ----------------------------------------------------------------------------
// Usage:
//   Radii are written through the cfg channel (cfg_valid/cfg_ready, index 0
//   is the first radius, index 1 the second, other indexes are dropped).
//   cfg_ready is always high; write only while no pair is in flight.
//   A pair beat is taken on every clock where start is high; busy stays low,
//   so a new pair may enter every cycle.
//   Each pair yields one result beat, marked by done for one cycle:
//   gap_distance, normal_x, normal_y and degenerate.
//   The path runs through the front stages (difference, magnitude, partial
//   products, squares, sum), one square root cell per root bit
//   (COORD_WIDTH + 1), one rounding stage, one divider cell per quotient bit
//   (17) and the output register. Throughput is one pair per cycle; the
//   square root and divider cell rows make up most of the pipeline.
//   The receiver cannot stall: results leave on done whether taken or not.
//   Reset clears the radii and all valid bits; payload flops are not reset.
// ----------------------------------------------------------------------------
module circle_ring_contact_gap_normal #(
	parameter int COORD_WIDTH = crcg_pkg::DEF_COORD_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_WIDTH-1:0]   first_x,
	input  logic signed [COORD_WIDTH-1:0]   first_y,
	input  logic signed [COORD_WIDTH-1:0]   second_x,
	input  logic signed [COORD_WIDTH-1:0]   second_y,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [crcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crcg_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            done,
	output logic signed [crcg_pkg::GAP_W-1:0]  gap_distance,
	output logic signed [crcg_pkg::NORM_W-1:0] normal_x,
	output logic signed [crcg_pkg::NORM_W-1:0] normal_y,
	output logic                            degenerate
);

	import crcg_pkg::*;

	// Root / magnitude width: |delta| needs one bit more than a coordinate
	localparam int R       = COORD_WIDTH + 1;
	localparam int SQ_W    = 2 * R;
	localparam int LO_W    = R / 2;
	localparam int HI_W    = R - LO_W;
	localparam int GW      = ((R > RADIUS_W) ? R : RADIUS_W) + 2;
	localparam int SQ_SIDE = 2 * R + 2;
	localparam int DX_SIDE = GAP_W + 2;
	localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << NORM_FRAC;

	// ---------------- configuration ----------------
	logic [RADIUS_W-1:0] radius_first_q;
	logic [RADIUS_W-1:0] radius_second_q;
	logic [RADIUS_W-1:0] rdiff_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_first_q  <= '0;
			radius_second_q <= '0;
			rdiff_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_RADIUS_FIRST:  radius_first_q  <= cfg_data[RADIUS_W-1:0];
					REG_RADIUS_SECOND: radius_second_q <= cfg_data[RADIUS_W-1:0];
					default: ;
				endcase
			end
			// hold |r1 - r2| ready for the gap stage
			rdiff_q <= (radius_first_q >= radius_second_q) ?
				(radius_first_q - radius_second_q) : (radius_second_q - radius_first_q);
		end
	end

	// ---------------- front stages ----------------
	logic                valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [R-1:0] dx_s1, dy_s1;
	logic [R-1:0]        ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4, ax_s5, ay_s5;
	logic                sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5;
	logic [2*HI_W-1:0]      xhh_s3, yhh_s3;
	logic [HI_W+LO_W-1:0]   xhl_s3, yhl_s3;
	logic [2*LO_W-1:0]      xll_s3, yll_s3;
	logic [SQ_W-1:0]        sqx_s4, sqy_s4, sum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// center differences
		dx_s1 <= R'(second_x) - R'(first_x);
		dy_s1 <= R'(second_y) - R'(first_y);
		// drop the sign, keep it aside
		sx_s2 <= dx_s1[R-1];
		sy_s2 <= dy_s1[R-1];
		ax_s2 <= dx_s1[R-1] ? (R'(0) - dx_s1) : dx_s1;
		ay_s2 <= dy_s1[R-1] ? (R'(0) - dy_s1) : dy_s1;
		// split squares into partial products
		xhh_s3 <= ax_s2[R-1:LO_W] * ax_s2[R-1:LO_W];
		xhl_s3 <= ax_s2[R-1:LO_W] * ax_s2[LO_W-1:0];
		xll_s3 <= ax_s2[LO_W-1:0] * ax_s2[LO_W-1:0];
		yhh_s3 <= ay_s2[R-1:LO_W] * ay_s2[R-1:LO_W];
		yhl_s3 <= ay_s2[R-1:LO_W] * ay_s2[LO_W-1:0];
		yll_s3 <= ay_s2[LO_W-1:0] * ay_s2[LO_W-1:0];
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
		sqx_s4 <= (SQ_W'(xhh_s3) << (2 * LO_W)) + (SQ_W'(xhl_s3) << (LO_W + 1))
			+ SQ_W'(xll_s3);
		sqy_s4 <= (SQ_W'(yhh_s3) << (2 * LO_W)) + (SQ_W'(yhl_s3) << (LO_W + 1))
			+ SQ_W'(yll_s3);
		ax_s4 <= ax_s3;
		ay_s4 <= ay_s3;
		sx_s4 <= sx_s3;
		sy_s4 <= sy_s3;
		sum_s5 <= sqx_s4 + sqy_s4;
		ax_s5  <= ax_s4;
		ay_s5  <= ay_s4;
		sx_s5  <= sx_s4;
		sy_s5  <= sy_s4;
	end

	// ---------------- square root cell row ----------------
	logic [R:0]             sq_valid;
	logic [SQ_W-1:0]        sq_rad  [R+1];
	logic [R+1:0]           sq_rem  [R+1];
	logic [R-1:0]           sq_root [R+1];
	logic [SQ_SIDE-1:0]     sq_side [R+1];

	assign sq_valid[0] = valid_s5;
	assign sq_rad[0]   = sum_s5;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_side[0]  = {sx_s5, sy_s5, ax_s5, ay_s5};

	for (genvar i = 0; i < R; i++) begin : g_sqrt
		crcg_sqrt_cell #(
			.ROOT_W(R),
			.SIDE_W(SQ_SIDE)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (sq_valid[i]),
			.rad_in   (sq_rad[i]),
			.rem_in   (sq_rem[i]),
			.root_in  (sq_root[i]),
			.side_in  (sq_side[i]),
			.valid_out(sq_valid[i+1]),
			.rad_out  (sq_rad[i+1]),
			.rem_out  (sq_rem[i+1]),
			.root_out (sq_root[i+1]),
			.side_out (sq_side[i+1])
		);
	end

	// ---------------- round to nearest ----------------
	logic         valid_s6;
	logic [R-1:0] d_s6, ax_s6, ay_s6;
	logic         sx_s6, sy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= sq_valid[R];
		end
	end

	always_ff @(posedge clk) begin
		d_s6 <= sq_root[R] + R'(sq_rem[R] > {2'b00, sq_root[R]});
		{sx_s6, sy_s6, ax_s6, ay_s6} <= sq_side[R];
	end

	// gap = |r1 - r2| - d, saturated to 32 bits
	logic [GW-1:0]    gap_w;
	logic [GAP_W-1:0] gap_sat;
	logic             gap_ovf;
	logic             degen;

	assign gap_w   = GW'(rdiff_q) - GW'(d_s6);
	assign gap_ovf = !((&gap_w[GW-1:GAP_W-1]) || !(|gap_w[GW-1:GAP_W-1]));
	assign gap_sat = gap_ovf ? {gap_w[GW-1], {(GAP_W-1){~gap_w[GW-1]}}}
		: gap_w[GAP_W-1:0];
	assign degen   = (d_s6 == '0);

	// ---------------- divider cell rows ----------------
	logic [QUOT_W:0]        dvx_valid, dvy_valid;
	logic [R-1:0]           dvx_den [QUOT_W+1];
	logic [R-1:0]           dvx_rem [QUOT_W+1];
	logic [QUOT_W-1:0]      dvx_nq  [QUOT_W+1];
	logic [DX_SIDE-1:0]     dvx_side[QUOT_W+1];
	logic [R-1:0]           dvy_den [QUOT_W+1];
	logic [R-1:0]           dvy_rem [QUOT_W+1];
	logic [QUOT_W-1:0]      dvy_nq  [QUOT_W+1];
	logic                   dvy_side[QUOT_W+1];

	// dividend is |delta| << 16; its top part |delta| >> 1 is already below d
	assign dvx_valid[0] = valid_s6;
	assign dvx_den[0]   = d_s6;
	assign dvx_rem[0]   = {1'b0, ax_s6[R-1:1]};
	assign dvx_nq[0]    = {ax_s6[0], {NORM_FRAC{1'b0}}};
	assign dvx_side[0]  = {degen, gap_sat, sx_s6};
	assign dvy_valid[0] = valid_s6;
	assign dvy_den[0]   = d_s6;
	assign dvy_rem[0]   = {1'b0, ay_s6[R-1:1]};
	assign dvy_nq[0]    = {ay_s6[0], {NORM_FRAC{1'b0}}};
	assign dvy_side[0]  = sy_s6;

	for (genvar j = 0; j < QUOT_W; j++) begin : g_div
		crcg_div_cell #(
			.DIV_W (R),
			.SIDE_W(DX_SIDE)
		) u_cell_x (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (dvx_valid[j]),
			.den_in   (dvx_den[j]),
			.rem_in   (dvx_rem[j]),
			.nq_in    (dvx_nq[j]),
			.side_in  (dvx_side[j]),
			.valid_out(dvx_valid[j+1]),
			.den_out  (dvx_den[j+1]),
			.rem_out  (dvx_rem[j+1]),
			.nq_out   (dvx_nq[j+1]),
			.side_out (dvx_side[j+1])
		);

		crcg_div_cell #(
			.DIV_W (R),
			.SIDE_W(1)
		) u_cell_y (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (dvy_valid[j]),
			.den_in   (dvy_den[j]),
			.rem_in   (dvy_rem[j]),
			.nq_in    (dvy_nq[j]),
			.side_in  (dvy_side[j]),
			.valid_out(dvy_valid[j+1]),
			.den_out  (dvy_den[j+1]),
			.rem_out  (dvy_rem[j+1]),
			.nq_out   (dvy_nq[j+1]),
			.side_out (dvy_side[j+1])
		);
	end

	// round half away from zero, clamp to one, restore the sign
	function automatic logic [NORM_W-1:0] norm_finish(
		input logic [QUOT_W-1:0] q,
		input logic [R-1:0]      rem,
		input logic [R-1:0]      den,
		input logic              neg
	);
		logic [NORM_W-1:0] qr;
		qr = NORM_W'(q) + NORM_W'({rem, 1'b0} >= {1'b0, den});
		if (qr > NORM_ONE) begin
			qr = NORM_ONE;
		end
		return neg ? (NORM_W'(0) - qr) : qr;
	endfunction

	// ---------------- output register ----------------
	logic x_degen;
	logic x_sign;
	logic [GAP_W-1:0] x_gap;

	assign {x_degen, x_gap, x_sign} = dvx_side[QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvx_valid[QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		gap_distance <= x_gap;
		degenerate   <= x_degen;
		normal_x     <= x_degen ? '0 :
			norm_finish(dvx_nq[QUOT_W], dvx_rem[QUOT_W], dvx_den[QUOT_W], x_sign);
		normal_y     <= x_degen ? '0 :
			norm_finish(dvy_nq[QUOT_W], dvy_rem[QUOT_W], dvy_den[QUOT_W],
				dvy_side[QUOT_W]);
	end

endmodule
